[rtl/core/tsj_pkg.sv]
// Shared widths, payload types and defaults for the tetrahedron scaled Jacobian block.
`default_nettype none

package tsj_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int QUEUE_DEFAULT = 4;
    localparam int PIECE_DEFAULT = 18;
    localparam int NUM_EDGES     = 6;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int LEN_W  = 2 * COORD_BITS + 2;
    localparam int CR_W   = 2 * COORD_BITS + 3;
    localparam int TERM_W = DIFF_W + CR_W;
    localparam int DET_W  = 3 * COORD_BITS + 5;
    localparam int DM_W   = 3 * COORD_BITS + 3;
    localparam int P2_W   = 2 * LEN_W;
    localparam int P_W    = 3 * LEN_W;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int DSQ_W  = 2 * DM_W;
    localparam int NUM_W  = DSQ_W + 2 * FRAC_BITS;
    localparam int CMP_W  = P_W + 2 * Q_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex1_x;
        logic signed [COORD_BITS-1:0] vertex1_y;
        logic signed [COORD_BITS-1:0] vertex1_z;
        logic signed [COORD_BITS-1:0] vertex2_x;
        logic signed [COORD_BITS-1:0] vertex2_y;
        logic signed [COORD_BITS-1:0] vertex2_z;
        logic signed [COORD_BITS-1:0] vertex3_x;
        logic signed [COORD_BITS-1:0] vertex3_y;
        logic signed [COORD_BITS-1:0] vertex3_z;
        logic signed [COORD_BITS-1:0] vertex4_x;
        logic signed [COORD_BITS-1:0] vertex4_y;
        logic signed [COORD_BITS-1:0] vertex4_z;
    } t_in;

    typedef struct packed {
        logic [FRAC_BITS:0] scaled_jacobian;
        logic               degenerate;
    } t_out;

    // Edge order: 1-2, 1-3, 1-4, 2-3, 2-4, 3-4; components x, y, z.
    typedef struct packed {
        logic [NUM_EDGES-1:0][2:0][DIFF_W-1:0] d;
        logic                                  degenerate;
    } t_entry;

endpackage

`default_nettype wire

[rtl/core/tet_scaled_jacobian.sv]
// Top level of the tetrahedron scaled Jacobian block.
// Takes one tetrahedron per clock (start high while busy is low) and returns one result per
// item on o_result with o_strobe high for one cycle, in acceptance order. Behind the edge,
// determinant and product stages sits the one-bit-per-stage root search (FRAC_BITS + 1
// stages); the receiver cannot stall, so the back end drains the queue every cycle and busy
// stays low in steady operation. A result with degenerate set carries a zero scaled_jacobian.
`default_nettype none

module tet_scaled_jacobian
    import tsj_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEFAULT,
    parameter int MUL_PIECE   = PIECE_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out      o_result
);

    logic   push, q_valid, q_afull, pop;
    t_entry f_entry, q_entry;

    tsj_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_q_afull (q_afull),
        .o_busy    (busy),
        .o_push    (push),
        .o_entry   (f_entry)
    );

    tsj_queue #(.WIDTH($bits(t_entry)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .o_afull (q_afull)
    );

    tsj_back #(.PIECE(MUL_PIECE)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[rtl/core/tsj_mul.sv]
// Two-stage unsigned multiplier built from registered partial products.
`default_nettype none

module tsj_mul #(
    parameter int A_W   = 34,
    parameter int B_W   = 34,
    parameter int PIECE = 18
) (
    input  wire logic               i_clk,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-1:0] o_p
);

    localparam int NA    = (A_W + PIECE - 1) / PIECE;
    localparam int NB    = (B_W + PIECE - 1) / PIECE;
    localparam int ACC_W = (NA + NB) * PIECE;

    logic [NA*PIECE-1:0]  a_x;
    logic [NB*PIECE-1:0]  b_x;
    logic [2*PIECE-1:0]   r_pp [NA][NB];
    logic [ACC_W-1:0]     acc;
    logic [A_W+B_W-1:0]   r_p;

    assign a_x = (NA*PIECE)'(i_a);
    assign b_x = (NB*PIECE)'(i_b);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= a_x[i*PIECE +: PIECE] * b_x[j*PIECE +: PIECE];
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (ACC_W'(r_pp[i][j]) << ((i + j) * PIECE));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= acc[A_W+B_W-1:0];
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[rtl/core/tsj_queue.sv]
// Small register queue between the front end and the arithmetic back end.
`default_nettype none

module tsj_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_afull
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_afull = (r_count >= CNT_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !do_pop && r_count == CNT_W'(DEPTH)))
        else $error("queue overflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

[rtl/core/tsj_front.sv]
// Front end: accept an item, form the edge vectors between every pair of vertices and flag zero-length edges.
`default_nettype none

module tsj_front
    import tsj_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_in    i_item,
    input  wire logic   i_q_afull,
    output logic        o_busy,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int EA [NUM_EDGES] = '{0, 0, 0, 1, 1, 2};
    localparam int EB [NUM_EDGES] = '{1, 2, 3, 2, 3, 3};

    logic signed [COORD_BITS-1:0] v [4][3];
    logic signed [DIFF_W-1:0]     diff [NUM_EDGES][3];
    t_entry                       n_entry;
    t_entry                       r_entry;
    logic                         r_valid;
    logic                         accept;

    assign v[0][0] = i_item.vertex1_x;
    assign v[0][1] = i_item.vertex1_y;
    assign v[0][2] = i_item.vertex1_z;
    assign v[1][0] = i_item.vertex2_x;
    assign v[1][1] = i_item.vertex2_y;
    assign v[1][2] = i_item.vertex2_z;
    assign v[2][0] = i_item.vertex3_x;
    assign v[2][1] = i_item.vertex3_y;
    assign v[2][2] = i_item.vertex3_z;
    assign v[3][0] = i_item.vertex4_x;
    assign v[3][1] = i_item.vertex4_y;
    assign v[3][2] = i_item.vertex4_z;

    assign o_busy = i_q_afull;
    assign accept = i_start && !i_q_afull;

    always_comb begin
        n_entry.degenerate = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < 3; k++) begin
                diff[e][k]       = DIFF_W'(v[EB[e]][k]) - DIFF_W'(v[EA[e]][k]);
                n_entry.d[e][k]  = diff[e][k];
            end
            // an edge has zero length only when all three components vanish
            if (diff[e][0] == '0 && diff[e][1] == '0 && diff[e][2] == '0) begin
                n_entry.degenerate = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_push  = r_valid;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

[rtl/core/tsj_root.sv]
// Pipelined bit-by-bit search for the largest q with q*q*P <= D*D * 2^(2*FRAC_BITS).
`default_nettype none

module tsj_root
    import tsj_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [P_W-1:0]   i_p,
    input  wire logic [DSQ_W-1:0] i_dsq,
    output logic      [Q_W-1:0]   o_q
);

    logic [Q_W-1:0]   r_q   [Q_W];
    logic [CMP_W-1:0] r_qp  [Q_W];
    logic [CMP_W-1:0] r_q2p [Q_W];
    logic [P_W-1:0]   r_p   [Q_W];
    logic [DSQ_W-1:0] r_dsq [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int B = FRAC_BITS - s;

        logic [Q_W-1:0]   q_in;
        logic [CMP_W-1:0] qp_in, q2p_in, cand, num;
        logic [P_W-1:0]   p_in;
        logic [DSQ_W-1:0] dsq_in;

        if (s == 0) begin : g_first
            assign q_in   = '0;
            assign qp_in  = '0;
            assign q2p_in = '0;
            assign p_in   = i_p;
            assign dsq_in = i_dsq;
        end else begin : g_next
            assign q_in   = r_q[s-1];
            assign qp_in  = r_qp[s-1];
            assign q2p_in = r_q2p[s-1];
            assign p_in   = r_p[s-1];
            assign dsq_in = r_dsq[s-1];
        end

        // (q + 2^B)^2 P = q^2 P + 2^(B+1) qP + 2^(2B) P
        assign cand = q2p_in + (qp_in << (B + 1)) + (CMP_W'(p_in) << (2 * B));
        assign num  = CMP_W'({dsq_in, {(2 * FRAC_BITS){1'b0}}});

        always_ff @(posedge i_clk) begin
            r_p[s]   <= p_in;
            r_dsq[s] <= dsq_in;
            if (cand <= num) begin
                r_q[s]   <= q_in | (Q_W'(1) << B);
                r_qp[s]  <= qp_in + (CMP_W'(p_in) << B);
                r_q2p[s] <= cand;
            end else begin
                r_q[s]   <= q_in;
                r_qp[s]  <= qp_in;
                r_q2p[s] <= q2p_in;
            end
        end
    end

    assign o_q = r_q[Q_W-1];

endmodule

`default_nettype wire

[rtl/core/tsj_back.sv]
// Back end: edge lengths, determinant, corner products, root search and minimum.
`default_nettype none

module tsj_back
    import tsj_pkg::*;
#(
    parameter int PIECE = PIECE_DEFAULT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_strobe,
    output t_out        o_result
);

    localparam int LAT = FRAC_BITS + 8;

    logic signed [DIFF_W-1:0]   d      [NUM_EDGES][3];
    logic signed [2*DIFF_W-1:0] sq_f   [NUM_EDGES][3];
    logic signed [2*DIFF_W-1:0] xp_f   [6];
    logic        [SQ_W-1:0]     r_sq   [NUM_EDGES][3];
    logic signed [2*DIFF_W-1:0] r_xp   [6];
    logic signed [DIFF_W-1:0]   r_e1a  [3];
    logic signed [DIFF_W-1:0]   r_e1b  [3];
    logic        [LEN_W-1:0]    r_len  [NUM_EDGES];
    logic signed [CR_W-1:0]     r_cr   [3];
    logic signed [TERM_W-1:0]   term_f [3];
    logic signed [TERM_W-1:0]   r_term [3];
    logic        [LEN_W-1:0]    r_l3   [4];
    logic        [LEN_W-1:0]    r_l4   [4];
    logic signed [DET_W-1:0]    det_s, det_a;
    logic        [DM_W-1:0]     r_dm;
    logic        [P2_W-1:0]     p2     [4];
    logic        [P_W-1:0]      p3     [4];
    logic        [DSQ_W-1:0]    dsq;
    logic        [Q_W-1:0]      q      [4];
    logic        [Q_W-1:0]      qmin;
    logic        [LAT-1:0]      r_vld;
    logic        [LAT-1:0]      r_dg;
    t_out                       r_res;

    // corner pairs for the first product and the third factor
    localparam int CA [4] = '{0, 0, 1, 2};
    localparam int CB [4] = '{1, 3, 3, 4};
    localparam int CC [4] = '{2, 4, 5, 5};

    assign o_pop = i_valid;

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < 3; k++) begin
                d[e][k]    = i_entry.d[e][k];
                sq_f[e][k] = d[e][k] * d[e][k];
            end
        end
        // e2 is edge 1-3, e3 is edge 1-4
        xp_f[0] = d[1][1] * d[2][2];
        xp_f[1] = d[1][2] * d[2][1];
        xp_f[2] = d[1][2] * d[2][0];
        xp_f[3] = d[1][0] * d[2][2];
        xp_f[4] = d[1][0] * d[2][1];
        xp_f[5] = d[1][1] * d[2][0];
        for (int k = 0; k < 3; k++) begin
            term_f[k] = r_e1b[k] * r_cr[k];
        end
        det_s = DET_W'(r_term[0]) + DET_W'(r_term[1]) + DET_W'(r_term[2]);
        det_a = (det_s < 0) ? -det_s : det_s;
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[e][k] <= sq_f[e][k][SQ_W-1:0];
            end
            r_len[e] <= LEN_W'(r_sq[e][0]) + LEN_W'(r_sq[e][1]) + LEN_W'(r_sq[e][2]);
        end
        for (int k = 0; k < 6; k++) begin
            r_xp[k] <= xp_f[k];
        end
        for (int k = 0; k < 3; k++) begin
            r_e1a[k]  <= d[0][k];
            r_e1b[k]  <= r_e1a[k];
            r_cr[k]   <= CR_W'(r_xp[2*k]) - CR_W'(r_xp[2*k+1]);
            r_term[k] <= term_f[k];
        end
        for (int c = 0; c < 4; c++) begin
            r_l3[c] <= r_len[CC[c]];
            r_l4[c] <= r_l3[c];
        end
        r_dm <= det_a[DM_W-1:0];
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
        tsj_mul #(.A_W(LEN_W), .B_W(LEN_W), .PIECE(PIECE)) u_mul_ab (
            .i_clk (i_clk),
            .i_a   (r_len[CA[c]]),
            .i_b   (r_len[CB[c]]),
            .o_p   (p2[c])
        );
        tsj_mul #(.A_W(P2_W), .B_W(LEN_W), .PIECE(PIECE)) u_mul_abc (
            .i_clk (i_clk),
            .i_a   (p2[c]),
            .i_b   (r_l4[c]),
            .o_p   (p3[c])
        );
        tsj_root u_root (
            .i_clk (i_clk),
            .i_p   (p3[c]),
            .i_dsq (dsq),
            .o_q   (q[c])
        );
    end

    tsj_mul #(.A_W(DM_W), .B_W(DM_W), .PIECE(PIECE)) u_mul_det (
        .i_clk (i_clk),
        .i_a   (r_dm),
        .i_b   (r_dm),
        .o_p   (dsq)
    );

    always_comb begin
        qmin = q[0];
        for (int c = 1; c < 4; c++) begin
            if (q[c] < qmin) begin
                qmin = q[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
        r_dg                  <= {r_dg[LAT-2:0], i_entry.degenerate};
        r_res.degenerate      <= r_dg[LAT-2];
        r_res.scaled_jacobian <= r_dg[LAT-2] ? '0 : qmin;
    end

    assign o_strobe = r_vld[LAT-1];
    assign o_result = r_res;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && r_dg[LAT-2]) |=> (o_result.scaled_jacobian == '0))
        else $error("degenerate item gave nonzero result");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.scaled_jacobian <= (Q_W'(1) << FRAC_BITS)))
        else $error("scaled jacobian above one");

endmodule

`default_nettype wire
